// ----- sv/packed_bcd_id_phone_table_top_macros.svh -----
// Assertion macros used by the phone table RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef PACKED_BCD_ID_PHONE_TABLE_TOP_MACROS_SVH
`define PACKED_BCD_ID_PHONE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PBCDT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pbcdt: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define PBCDT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pbcdt: next-cycle check failed");

`endif

// ----- sv/pbcdt_pkg.sv -----
// Shared types, constants and BCD pack/unpack helpers for the phone table.
// No dependencies; used by pbcdt_cell and packed_bcd_id_phone_table_top.
package pbcdt_pkg;

	localparam int TABLE_DEPTH  = 64;
	localparam int SLOT_W       = 6;
	localparam int CNT_W        = 7;
	localparam int ID_DIGITS    = 8;
	localparam int HEAD_DIGITS  = 3;
	localparam int TAIL_DIGITS  = 7;
	localparam int PHONE_DIGITS = HEAD_DIGITS + TAIL_DIGITS;
	localparam int KEY_W        = 4 * ID_DIGITS;
	localparam int PHONE_W      = 4 * PHONE_DIGITS;

	// High nibble of an ASCII digit
	localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

	typedef enum logic [0:0] {
		FUNC_INSERT = 1'b0,
		FUNC_LOOKUP = 1'b1
	} func_t;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [PHONE_W-1:0] phone_t;

	typedef struct packed {
		func_t                      func;
		slot_t                      slot;
		logic [8*ID_DIGITS-1:0]     id_ascii;
		logic [8*HEAD_DIGITS-1:0]   phone_head_ascii;
		logic [8*TAIL_DIGITS-1:0]   phone_tail_ascii;
	} req_t;

	typedef struct packed {
		logic                       found;
		logic [8*HEAD_DIGITS-1:0]   phone_head_out;
		logic [8*TAIL_DIGITS-1:0]   phone_tail_out;
	} rsp_t;

	// Broadcast write to the cell row
	typedef struct packed {
		logic   en;
		slot_t  slot;
		key_t   key;
		phone_t phone;
	} wr_t;

	// Search word that walks the cell row, one cell per cycle
	typedef struct packed {
		logic   vld;
		key_t   key;
		logic   key_ok;
		cnt_t   left;
		logic   found;
		phone_t phone;
	} srch_t;

	// Pack eight ASCII id characters; (ch - '0') & 0xF is the low nibble of ch
	function automatic key_t pack_id(input logic [8*ID_DIGITS-1:0] id);
		key_t k;
		k = '0;
		for (int i = 0; i < ID_DIGITS; i++) begin
			k[4*i +: 4] = id[8*i +: 4];
		end
		return k;
	endfunction

	// An id can only match when every character is in '0'..'?'
	function automatic logic id_is_digit_range(input logic [8*ID_DIGITS-1:0] id);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < ID_DIGITS; i++) begin
			if (id[8*i+4 +: 4] != ASCII_DIGIT_HI) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	function automatic phone_t pack_phone(input logic [8*HEAD_DIGITS-1:0] head,
			input logic [8*TAIL_DIGITS-1:0] tail);
		phone_t p;
		p = '0;
		for (int i = 0; i < TAIL_DIGITS; i++) begin
			p[4*i +: 4] = tail[8*i +: 4];
		end
		for (int i = 0; i < HEAD_DIGITS; i++) begin
			p[4*(TAIL_DIGITS+i) +: 4] = head[8*i +: 4];
		end
		return p;
	endfunction

	// Expand stored nibbles back to ASCII digits
	function automatic rsp_t unpack_result(input logic found, input phone_t p);
		rsp_t r;
		r = '0;
		if (found) begin
			r.found = 1'b1;
			for (int i = 0; i < TAIL_DIGITS; i++) begin
				r.phone_tail_out[8*i +: 8] = {ASCII_DIGIT_HI, p[4*i +: 4]};
			end
			for (int i = 0; i < HEAD_DIGITS; i++) begin
				r.phone_head_out[8*i +: 8] = {ASCII_DIGIT_HI, p[4*(TAIL_DIGITS+i) +: 4]};
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/pbcdt_cell.sv -----
// One table slot: holds a packed key and phone word and checks the passing search word.
// Depends on pbcdt_pkg.
module pbcdt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  pbcdt_pkg::slot_t  cell_idx,
	input  pbcdt_pkg::wr_t    wr,
	input  pbcdt_pkg::srch_t  srch_in,
	output pbcdt_pkg::srch_t  srch_out
);
	import pbcdt_pkg::*;

	key_t   key_q;
	phone_t phone_q;
	logic   vld_q;
	srch_t  pay_q;
	srch_t  nxt;
	logic   live;
	logic   hit;

	// Store the record addressed to this slot
	always_ff @(posedge clk) begin
		if (wr.en && (wr.slot == cell_idx)) begin
			key_q   <= wr.key;
			phone_q <= wr.phone;
		end
	end

	// Compare only while the slot is inside the searched range and nothing matched yet
	assign live = srch_in.vld && (srch_in.left != '0);
	assign hit  = live && srch_in.key_ok && !srch_in.found && (srch_in.key == key_q);

	always_comb begin
		nxt = srch_in;
		if (live) begin
			nxt.left = srch_in.left - cnt_t'(1);
		end
		if (hit) begin
			nxt.found = 1'b1;
			nxt.phone = phone_q;
		end
	end

	// Advance the search word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= srch_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	always_comb begin
		srch_out     = pay_q;
		srch_out.vld = vld_q;
	end

endmodule

// ----- sv/packed_bcd_id_phone_table_top.sv -----
// Packed BCD id/phone table: top level with the cell row and the result buffer.
// Depends on pbcdt_pkg, pbcdt_cell and packed_bcd_id_phone_table_top_macros.svh.
//
// Usage:
//   req channel (req_valid / req_stall / req): one word per item. func selects insert
//   or lookup. An insert packs id and phone to BCD and writes them into the given slot.
//   A lookup walks the search word through a row of 64 slot cells, one cell per
//   cycle; the first cell below entry_count whose key matches supplies the phone.
//   rsp channel (rsp_valid / rsp_stall / rsp): one word per item, in order.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes entry_count; always ready.
//   Write it only while no item is in flight.
// Flow:
//   Insert: the result word goes into the output register, or into the pending register
//   while rsp_stall holds the output; inserts can be taken every cycle while the receiver
//   keeps up and no lookup is in flight.
//   Lookup: the result word passes the 64-cell row, then the output register; one lookup
//   is in the row at a time and the next word is taken only once it leaves the row.
// Stall: a result waiting on rsp_stall sits in the output register; one more result
//   can park in a pending register, after which req_stall stays high until drained.
// Reset: clears entry_count, the valid flags and the busy state; slot contents stay
//   undefined until written.
module packed_bcd_id_phone_table_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  pbcdt_pkg::req_t     req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pbcdt_pkg::rsp_t     rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  pbcdt_pkg::cnt_t     cfg_data
);
	import pbcdt_pkg::*;

	`include "packed_bcd_id_phone_table_top_macros.svh"

	cnt_t  entry_count_q;
	logic  busy_q;
	logic  rsp_valid_q;
	logic  pend_valid_q;
	rsp_t  rsp_q;
	rsp_t  pend_q;

	logic  acc;
	logic  ins_acc;
	logic  look_acc;
	wr_t   wr;
	srch_t srch_head;
	srch_t chain [0:TABLE_DEPTH];
	logic  fin_vld;
	rsp_t  fin;
	logic  out_free;

	assign cfg_ready = 1'b1;
	assign req_stall = busy_q || pend_valid_q;
	assign acc       = req_valid && !req_stall;
	assign ins_acc   = acc && (req.func == FUNC_INSERT);
	assign look_acc  = acc && (req.func == FUNC_LOOKUP);

	// Hold the search length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			entry_count_q <= cfg_data;
		end
	end

	// Broadcast the insert and launch the lookup word into the first cell
	always_comb begin
		wr.en    = ins_acc;
		wr.slot  = req.slot;
		wr.key   = pack_id(req.id_ascii);
		wr.phone = pack_phone(req.phone_head_ascii, req.phone_tail_ascii);

		srch_head.vld    = look_acc;
		srch_head.key    = pack_id(req.id_ascii);
		srch_head.key_ok = id_is_digit_range(req.id_ascii);
		srch_head.left   = entry_count_q;
		srch_head.found  = 1'b0;
		srch_head.phone  = '0;
	end

	assign chain[0] = srch_head;

	// Row of slot cells
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		pbcdt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (slot_t'(g)),
			.wr       (wr),
			.srch_in  (chain[g]),
			.srch_out (chain[g+1])
		);
	end

	// Track the lookup in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (look_acc) begin
			busy_q <= 1'b1;
		end else if (chain[TABLE_DEPTH].vld) begin
			busy_q <= 1'b0;
		end
	end

	// Finished word: inserts report zeros, lookups unpack the row output
	assign fin_vld  = ins_acc || chain[TABLE_DEPTH].vld;
	assign fin      = ins_acc ? rsp_t'('0)
		: unpack_result(chain[TABLE_DEPTH].found, chain[TABLE_DEPTH].phone);
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Output register plus one pending word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			priority if (out_free && pend_valid_q) begin
				rsp_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (out_free) begin
				rsp_valid_q  <= fin_vld;
			end else if (fin_vld) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (out_free && pend_valid_q) begin
			rsp_q <= pend_q;
		end else if (out_free && fin_vld) begin
			rsp_q <= fin;
		end else if (!out_free && fin_vld) begin
			pend_q <= fin;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A parked word always sits behind a valid output word
	`PBCDT_ASSERT_NOW(a_pend_behind_out, pend_valid_q, rsp_valid_q)
	// Nothing finishes while a word is parked
	`PBCDT_ASSERT_NOW(a_no_fin_when_pend, pend_valid_q, !fin_vld)
	// The row only emits a search word for a lookup in flight
	`PBCDT_ASSERT_NOW(a_row_out_busy, chain[TABLE_DEPTH].vld, busy_q)
	// An accepted lookup blocks further items
	`PBCDT_ASSERT_NXT(a_lookup_blocks, look_acc, busy_q && req_stall)

endmodule

// ----- test/tb_packed_bcd_id_phone_table_top.sv -----
`timescale 1ns / 100ps
// Testbench for packed_bcd_id_phone_table_top: directed and random insert/lookup traffic,
// checked word by word against a behavioral table model. Depends on pbcdt_pkg and the RTL.
module tb_packed_bcd_id_phone_table_top;
	import pbcdt_pkg::*;

	localparam int         CLK_HALF    = 4;
	localparam int         CYCLE_LIMIT = 1_000_000;
	localparam int         PRINT_LIMIT = 40;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [3:0] DIGIT_HI    = 4'h3;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;
	logic  cfg_valid = 1'b0;
	logic  cfg_ready;
	cnt_t  cfg_data  = '0;

	// Model of the table contents and the searched slot count
	key_t   key_tbl [TABLE_DEPTH];
	phone_t phone_tbl [TABLE_DEPTH];
	cnt_t   table_count;
	logic [63:0] id_pool [8];

	rsp_t answer_q [$];

	int send_idle_pct  = 0;
	int rcv_stall_pct  = 0;
	int error_count    = 0;
	int cycle_count    = 0;
	int inserts_sent   = 0;
	int lookups_sent   = 0;
	int lookup_hits    = 0;
	int answers_seen   = 0;
	int count_writes   = 0;

	packed_bcd_id_phone_table_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
				answer_q.size());
			$display("tb_packed_bcd_id_phone_table_top: FAIL");
			$finish;
		end
	end

	// Randomly hold off result words
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (error_count < PRINT_LIMIT) begin
			$display("mismatch at answer %0d: %s got %h want %h", answers_seen, what, got,
				want);
		end
		error_count++;
	endtask

	// ---- table model ----

	// Pack eight id characters, first character in the top nibble
	function automatic key_t bcd_key_of(input logic [63:0] id);
		key_t       k;
		logic [7:0] d;
		k = '0;
		for (int i = 0; i < ID_DIGITS; i++) begin
			d = id[8*(ID_DIGITS-1-i) +: 8] - ASCII_ZERO;
			k = {k[KEY_W-5:0], d[3:0]};
		end
		return k;
	endfunction

	function automatic phone_t bcd_phone_of(input logic [23:0] head, input logic [55:0] tail);
		phone_t     p;
		logic [7:0] d;
		p = '0;
		for (int i = 0; i < HEAD_DIGITS; i++) begin
			d = head[8*(HEAD_DIGITS-1-i) +: 8] - ASCII_ZERO;
			p = {p[PHONE_W-5:0], d[3:0]};
		end
		for (int i = 0; i < TAIL_DIGITS; i++) begin
			d = tail[8*(TAIL_DIGITS-1-i) +: 8] - ASCII_ZERO;
			p = {p[PHONE_W-5:0], d[3:0]};
		end
		return p;
	endfunction

	// Each id character must equal its stored nibble as an ASCII digit
	function automatic logic key_hit(input key_t k, input logic [63:0] id);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < ID_DIGITS; i++) begin
			if (id[8*(ID_DIGITS-1-i) +: 8] != {DIGIT_HI, k[4*(ID_DIGITS-1-i) +: 4]}) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	// Expand phone nibbles first..first+cnt-1 (0 = leading digit) to ASCII
	function automatic logic [55:0] phone_digits(input phone_t p, input int first,
			input int cnt);
		logic [55:0] r;
		r = '0;
		for (int i = 0; i < cnt; i++) begin
			r = {r[47:0], DIGIT_HI, p[4*(PHONE_DIGITS-1-first-i) +: 4]};
		end
		return r;
	endfunction

	function automatic logic [63:0] id_text_of(input key_t k);
		logic [63:0] t;
		t = '0;
		for (int i = 0; i < ID_DIGITS; i++) begin
			t = {t[55:0], DIGIT_HI, k[4*(ID_DIGITS-1-i) +: 4]};
		end
		return t;
	endfunction

	function automatic int searched_slots();
		return (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
	endfunction

	// Apply one accepted word to the table model and return its answer
	function automatic rsp_t apply_to_table(input req_t w);
		rsp_t        r;
		logic        hit;
		logic [55:0] digits;
		r   = '0;
		hit = 1'b0;
		if (w.func == FUNC_INSERT) begin
			key_tbl[w.slot]   = bcd_key_of(w.id_ascii);
			phone_tbl[w.slot] = bcd_phone_of(w.phone_head_ascii, w.phone_tail_ascii);
			inserts_sent++;
		end else begin
			for (int s = 0; s < searched_slots(); s++) begin
				if (!hit && key_hit(key_tbl[s], w.id_ascii)) begin
					hit              = 1'b1;
					r.found          = 1'b1;
					digits           = phone_digits(phone_tbl[s], 0, HEAD_DIGITS);
					r.phone_head_out = digits[23:0];
					r.phone_tail_out = phone_digits(phone_tbl[s], HEAD_DIGITS, TAIL_DIGITS);
				end
			end
			lookups_sent++;
			if (hit) begin
				lookup_hits++;
			end
		end
		return r;
	endfunction

	// ---- result checking ----

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			answers_seen++;
			if (answer_q.size() == 0) begin
				report_mismatch("unexpected word, found", 64'(rsp.found), 64'h0);
			end else begin
				want = answer_q.pop_front();
				if (rsp.found !== want.found) begin
					report_mismatch("found", 64'(rsp.found), 64'(want.found));
				end
				if (rsp.phone_head_out !== want.phone_head_out) begin
					report_mismatch("phone_head_out", 64'(rsp.phone_head_out),
						64'(want.phone_head_out));
				end
				if (rsp.phone_tail_out !== want.phone_tail_out) begin
					report_mismatch("phone_tail_out", 64'(rsp.phone_tail_out),
						64'(want.phone_tail_out));
				end
			end
		end
	end

	// ---- stimulus helpers ----

	function automatic logic [63:0] random_digits(input int n);
		logic [63:0] v;
		logic [7:0]  d;
		v = '0;
		for (int i = 0; i < n; i++) begin
			d = 8'($urandom_range(9));
			v = {v[55:0], ASCII_ZERO + d};
		end
		return v;
	endfunction

	function automatic logic [63:0] random_raw();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t insert_word(input slot_t s, input logic [63:0] id,
			input logic [23:0] head, input logic [55:0] tail);
		req_t w;
		w.func             = FUNC_INSERT;
		w.slot             = s;
		w.id_ascii         = id;
		w.phone_head_ascii = head;
		w.phone_tail_ascii = tail;
		return w;
	endfunction

	// Slot and phone are ignored on lookup; fill them with noise
	function automatic req_t lookup_word(input logic [63:0] id);
		req_t        w;
		logic [63:0] noise;
		logic [63:0] tail_noise;
		noise              = random_raw();
		tail_noise         = random_raw();
		w.func             = FUNC_LOOKUP;
		w.slot             = noise[5:0];
		w.id_ascii         = id;
		w.phone_head_ascii = noise[63:40];
		w.phone_tail_ascii = tail_noise[55:0];
		return w;
	endfunction

	// Mostly well-formed digit records, some raw noise
	function automatic req_t random_record(input slot_t s);
		logic [63:0] id;
		logic [63:0] head;
		logic [63:0] tail;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 30) begin
			id = id_pool[3'($urandom_range(7))];
		end else if (pick < 42) begin
			id = random_raw();
		end else begin
			id = random_digits(ID_DIGITS);
		end
		if ($urandom_range(99) < 85) begin
			head = random_digits(HEAD_DIGITS);
			tail = random_digits(TAIL_DIGITS);
		end else begin
			head = random_raw();
			tail = random_raw();
		end
		return insert_word(s, id, head[23:0], tail[55:0]);
	endfunction

	function automatic req_t random_item();
		int pick;
		if ($urandom_range(99) < 40) begin
			return random_record(slot_t'($urandom_range(TABLE_DEPTH-1)));
		end
		pick = $urandom_range(99);
		if (pick < 45 && searched_slots() > 0) begin
			return lookup_word(id_text_of(key_tbl[slot_t'($urandom_range(searched_slots()-1))]));
		end else if (pick < 70) begin
			return lookup_word(id_pool[3'($urandom_range(7))]);
		end else if (pick < 85) begin
			return lookup_word(random_digits(ID_DIGITS));
		end
		return lookup_word(random_raw());
	endfunction

	// Offer one word after a random gap; hold it until accepted
	task automatic send_word(input req_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		answer_q.push_back(apply_to_table(w));
		@(negedge clk);
	endtask

	// Drop valid and wait until every answer has come back
	task automatic wait_answers_drained();
		req_valid <= 1'b0;
		@(negedge clk);
		while (answer_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (2) @(negedge clk);
	endtask

	task automatic write_entry_count(input cnt_t v);
		wait_answers_drained();
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		table_count = v;
		count_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		rcv_stall_pct = stall_pct;
	endtask

	// ---- tests ----

	// Count is zero after reset: nothing can match
	task automatic test_empty_table();
		send_word(lookup_word("00000000"));
		send_word(lookup_word(64'hFFFF_FFFF_FFFF_FFFF));
		send_word(lookup_word(64'h0));
	endtask

	// Field extremes, non-digit characters, duplicate keys and a miss
	task automatic test_insert_and_lookup();
		send_word(insert_word(6'd0, "12345678", "052", "1234567"));
		send_word(insert_word(6'd1, 64'h0, 24'hFF_FFFF, 56'hFF_FFFF_FFFF_FFFF));
		send_word(insert_word(6'd2, 64'hFFFF_FFFF_FFFF_FFFF, 24'h0, 56'h0));
		send_word(insert_word(6'd3, "12345678", "000", "0000000"));
		send_word(insert_word(6'd4, ":;<=>?90", "987", "6543210"));
		send_word(insert_word(6'd63, "99999999", "555", "0199999"));
		write_entry_count(cnt_t'(5));
		send_word(lookup_word("12345678"));
		send_word(lookup_word("00000000"));
		send_word(lookup_word(64'h0));
		send_word(lookup_word("????????"));
		send_word(lookup_word(":;<=>?90"));
		send_word(lookup_word("11111111"));
		send_word(lookup_word("99999999"));
	endtask

	// Write every slot that is still empty so any count is safe to search
	task automatic fill_table();
		for (int s = 5; s < TABLE_DEPTH - 1; s++) begin
			send_word(random_record(slot_t'(s)));
		end
	endtask

	// Last slot reachable only at full count; counts above the depth clamp
	task automatic test_count_extremes();
		write_entry_count(cnt_t'(TABLE_DEPTH));
		send_word(lookup_word("99999999"));
		write_entry_count(cnt_t'(127));
		send_word(lookup_word("99999999"));
		send_word(lookup_word(":;<=>?90"));
		write_entry_count(cnt_t'(TABLE_DEPTH - 1));
		send_word(lookup_word("99999999"));
		write_entry_count(cnt_t'(1));
		send_word(lookup_word("12345678"));
		send_word(lookup_word("????????"));
	endtask

	task automatic test_random_traffic(input int n_items, input cnt_t first_count);
		write_entry_count(first_count);
		for (int n = 0; n < n_items; n++) begin
			// Change the count now and then, or just let the pipe run dry
			if (n % 80 == 79) begin
				write_entry_count(cnt_t'($urandom_range(127)));
			end else if (n % 97 == 50 || $urandom_range(63) == 0) begin
				wait_answers_drained();
			end
			send_word(random_item());
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++) begin
			id_pool[i] = random_digits(ID_DIGITS);
		end
		for (int s = 0; s < TABLE_DEPTH; s++) begin
			key_tbl[s]   = '0;
			phone_tbl[s] = '0;
		end
		table_count = '0;

		// Hold reset, release at a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(0, 0);
		test_empty_table();
		test_insert_and_lookup();
		fill_table();
		test_count_extremes();

		set_idling(0, 0);
		test_random_traffic(230, cnt_t'(TABLE_DEPTH));
		set_idling(76, 0);
		test_random_traffic(230, cnt_t'(127));
		set_idling(0, 76);
		test_random_traffic(230, cnt_t'($urandom_range(1, TABLE_DEPTH - 1)));
		set_idling(28, 28);
		test_random_traffic(230, cnt_t'($urandom_range(127)));

		wait_answers_drained();
		repeat (100) @(posedge clk);
		$display("covered %0d inserts and %0d lookups (%0d hits) over %0d count writes,",
			inserts_sent, lookups_sent, lookup_hits, count_writes);
		$display("four idle/stall mixes; %0d answers checked, %0d mismatches",
			answers_seen, error_count);
		if (error_count == 0 && answer_q.size() == 0) begin
			$display("tb_packed_bcd_id_phone_table_top: PASS");
		end else begin
			$display("tb_packed_bcd_id_phone_table_top: FAIL");
		end
		$finish;
	end

endmodule
